// File: hw/rtl/fev_pkg.sv
// ============================================================================
// fev_pkg
// Shared widths, command codes, controller states and the tag that travels
// with each product term from the controller through the datapath pipeline.
// ============================================================================
package fev_pkg;

   // element and result formats
   localparam int ELEM_W     = 32;   // Q8.24 matrix element
   localparam int PROD_W     = 64;   // coefficient times coefficient
   localparam int TERM_W     = 97;   // doubled product with covariance
   localparam int ACC_W      = 128;  // exact running sum
   localparam int RES_W      = 64;   // Q32.32 result
   localparam int FRAC_SHIFT = 40;   // accumulator fraction bits above Q32.32

   // port field widths
   localparam int CMD_W = 2;
   localparam int IDX_W = 3;
   localparam int HZ_W  = 4;
   localparam int NV_W  = 4;
   localparam int HC_W  = 5;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // size defaults and register reset values
   localparam int             MAX_VARS_DEF      = 8;
   localparam int             MAX_HORIZON_DEF   = 16;
   localparam logic [NV_W-1:0] NUM_VARS_RST      = 4'd8;
   localparam logic [HC_W-1:0] HORIZON_COUNT_RST = 5'd16;

   // command codes on req_cmd
   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_COV  = 2'd0,
      CMD_LOAD_COEF = 2'd1,
      CMD_START     = 2'd2
   } cmd_code_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_RUN   = 2'd1,
      ST_DRAIN = 2'd2
   } fev_state_type;

   // tag carried alongside every product term
   typedef struct packed {
      logic             valid;
      logic             first;      // first term of a variable, clears the sum
      logic             done;       // last term of a variable, emits a result
      logic             final_var;  // last variable of the run
      logic             diag;       // diagonal term, not doubled
      logic [IDX_W-1:0] var_idx;
   } fev_tag_type;

   // controller to datapath commands
   typedef struct packed {
      logic        cov_we;
      logic        coef_we;
      fev_tag_type tag;
   } fev_cmd_type;

endpackage

// File: hw/rtl/fev_regs.sv
// ============================================================================
// fev_regs
// Register file behind the APB-style port: number of variables and number of
// horizons. Word address bit 2 selects the register, low bits are ignored.
// ============================================================================
module fev_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fev_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [fev_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [fev_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output logic [fev_pkg::NV_W-1:0]          num_vars,
   output logic [fev_pkg::HC_W-1:0]          horizon_count
);

   typedef enum logic {
      REG_NUM_VARS      = 1'b0,
      REG_HORIZON_COUNT = 1'b1
   } reg_index_type;

   logic [fev_pkg::NV_W-1:0] num_vars_ff, num_vars_in;
   logic [fev_pkg::HC_W-1:0] horizon_count_ff, horizon_count_in;
   reg_index_type            reg_sel;
   logic                     wr_beat;

   assign reg_sel = reg_index_type'(paddr[2]);
   assign wr_beat = psel && penable && pwrite;
   assign pready  = 1'b1;

   // register write
   always_comb begin
      num_vars_in      = num_vars_ff;
      horizon_count_in = horizon_count_ff;
      if (wr_beat) begin
         case (reg_sel)
            REG_NUM_VARS: begin
               num_vars_in = pwdata[fev_pkg::NV_W-1:0];
            end
            REG_HORIZON_COUNT: begin
               horizon_count_in = pwdata[fev_pkg::HC_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vars_ff      <= fev_pkg::NUM_VARS_RST;
         horizon_count_ff <= fev_pkg::HORIZON_COUNT_RST;
      end else begin
         num_vars_ff      <= num_vars_in;
         horizon_count_ff <= horizon_count_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         REG_NUM_VARS:      prdata = fev_pkg::CSR_DATA_W'(num_vars_ff);
         REG_HORIZON_COUNT: prdata = fev_pkg::CSR_DATA_W'(horizon_count_ff);
         default:           prdata = '0;
      endcase
   end

   assign num_vars      = num_vars_ff;
   assign horizon_count = horizon_count_ff;

endmodule

// File: hw/rtl/fev_ctrl.sv
// ============================================================================
// fev_ctrl
// Controller: decodes command beats, and on start walks variable, horizon,
// column j and column k >= j, issuing one product term per cycle.
// ============================================================================
module fev_ctrl #(
   parameter int MAX_VARS    = fev_pkg::MAX_VARS_DEF,
   parameter int MAX_HORIZON = fev_pkg::MAX_HORIZON_DEF,
   localparam int VW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1,
   localparam int HW = (MAX_HORIZON > 1) ? $clog2(MAX_HORIZON) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [fev_pkg::CMD_W-1:0]   req_cmd,
   input  logic [fev_pkg::IDX_W-1:0]   req_row_index,
   input  logic [fev_pkg::IDX_W-1:0]   req_col_index,
   input  logic [fev_pkg::HZ_W-1:0]    req_horizon_index,
   input  logic [fev_pkg::NV_W-1:0]    num_vars,
   input  logic [fev_pkg::HC_W-1:0]    horizon_count,
   input  logic                        pipe_busy,
   output fev_pkg::fev_cmd_type        cmd,
   output logic [HW-1:0]               rd_h,
   output logic [VW-1:0]               rd_i,
   output logic [VW-1:0]               rd_j,
   output logic [VW-1:0]               rd_k
);

   fev_pkg::fev_state_type state_ff, state_in;
   logic [VW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, nm1_ff, nm1_in;
   logic [HW-1:0] h_ff, h_in, hcm1_ff, hcm1_in;
   logic [31:0]   nv_c, hc_c;
   logic          accept, row_ok, col_ok, hz_ok;
   logic          k_end, j_end, h_end, i_end;

   assign accept = start && (state_ff == fev_pkg::ST_IDLE);
   assign busy   = (state_ff != fev_pkg::ST_IDLE);

   // load bounds
   assign row_ok = 32'(req_row_index) < MAX_VARS;
   assign col_ok = 32'(req_col_index) < MAX_VARS;
   assign hz_ok  = 32'(req_horizon_index) < MAX_HORIZON;

   // clamp run sizes to 1..max
   always_comb begin
      nv_c = 32'(num_vars);
      if (nv_c == 32'd0) begin
         nv_c = 32'd1;
      end else if (nv_c > MAX_VARS) begin
         nv_c = 32'(MAX_VARS);
      end
      hc_c = 32'(horizon_count);
      if (hc_c == 32'd0) begin
         hc_c = 32'd1;
      end else if (hc_c > MAX_HORIZON) begin
         hc_c = 32'(MAX_HORIZON);
      end
   end

   assign k_end = (k_ff == nm1_ff);
   assign j_end = (j_ff == nm1_ff);
   assign h_end = (h_ff == hcm1_ff);
   assign i_end = (i_ff == nm1_ff);

   // next state, counters and commands
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      h_in     = h_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      nm1_in   = nm1_ff;
      hcm1_in  = hcm1_ff;
      cmd      = '0;
      case (state_ff)
         fev_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  fev_pkg::CMD_LOAD_COV: begin
                     cmd.cov_we = row_ok && col_ok;
                  end
                  fev_pkg::CMD_LOAD_COEF: begin
                     cmd.coef_we = row_ok && col_ok && hz_ok;
                  end
                  fev_pkg::CMD_START: begin
                     state_in = fev_pkg::ST_RUN;
                     i_in     = '0;
                     h_in     = '0;
                     j_in     = '0;
                     k_in     = '0;
                     nm1_in   = VW'(nv_c - 32'd1);
                     hcm1_in  = HW'(hc_c - 32'd1);
                  end
                  default: begin
                  end
               endcase
            end
         end
         fev_pkg::ST_RUN: begin
            cmd.tag.valid     = 1'b1;
            cmd.tag.first     = (h_ff == '0) && (j_ff == '0) && (k_ff == '0);
            cmd.tag.done      = k_end && j_end && h_end;
            cmd.tag.final_var = k_end && j_end && h_end && i_end;
            cmd.tag.diag      = (j_ff == k_ff);
            cmd.tag.var_idx   = fev_pkg::IDX_W'(i_ff);
            // k runs j..n-1, then j, then h, then i
            if (!k_end) begin
               k_in = k_ff + 1'b1;
            end else if (!j_end) begin
               j_in = j_ff + 1'b1;
               k_in = j_ff + 1'b1;
            end else begin
               j_in = '0;
               k_in = '0;
               if (!h_end) begin
                  h_in = h_ff + 1'b1;
               end else begin
                  h_in = '0;
                  if (!i_end) begin
                     i_in = i_ff + 1'b1;
                  end else begin
                     state_in = fev_pkg::ST_DRAIN;
                  end
               end
            end
         end
         fev_pkg::ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = fev_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fev_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fev_pkg::ST_IDLE;
         i_ff     <= '0;
         h_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         nm1_ff   <= '0;
         hcm1_ff  <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         h_ff     <= h_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         nm1_ff   <= nm1_in;
         hcm1_ff  <= hcm1_in;
      end
   end

   assign rd_h = h_ff;
   assign rd_i = i_ff;
   assign rd_j = j_ff;
   assign rd_k = k_ff;

endmodule

// File: hw/rtl/fev_dp.sv
// ============================================================================
// fev_dp
// Datapath: covariance and coefficient memories, a five-stage term pipeline
// (read, a_j*a_k, split product times covariance, combine and double,
// accumulate), then floor to Q32.32 with saturation into the result register.
// ============================================================================
module fev_dp #(
   parameter int MAX_VARS    = fev_pkg::MAX_VARS_DEF,
   parameter int MAX_HORIZON = fev_pkg::MAX_HORIZON_DEF,
   localparam int VW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1,
   localparam int HW = (MAX_HORIZON > 1) ? $clog2(MAX_HORIZON) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  fev_pkg::fev_cmd_type               cmd,
   input  logic [HW-1:0]                      rd_h,
   input  logic [VW-1:0]                      rd_i,
   input  logic [VW-1:0]                      rd_j,
   input  logic [VW-1:0]                      rd_k,
   input  logic [fev_pkg::IDX_W-1:0]          req_row_index,
   input  logic [fev_pkg::IDX_W-1:0]          req_col_index,
   input  logic [fev_pkg::HZ_W-1:0]           req_horizon_index,
   input  logic signed [fev_pkg::ELEM_W-1:0]  req_elem_value,
   output logic                               pipe_busy,
   output logic                               rsp_valid,
   output logic [fev_pkg::IDX_W-1:0]          rsp_var_index,
   output logic signed [fev_pkg::RES_W-1:0]   rsp_variance,
   output logic                               rsp_last
);

   localparam int COV_AW    = 2 * VW;
   localparam int COEF_AW   = HW + 2 * VW;
   localparam int COV_DEPTH  = 1 << COV_AW;
   localparam int COEF_DEPTH = 1 << COEF_AW;
   localparam int E_W   = fev_pkg::ELEM_W;
   localparam int P_W   = fev_pkg::PROD_W;
   localparam int HALF  = P_W / 2;
   localparam int SUM_W = P_W + E_W;              // combined product width
   localparam int T_W   = fev_pkg::TERM_W;
   localparam int A_W   = fev_pkg::ACC_W;
   localparam int R_W   = fev_pkg::RES_W;
   localparam int TOP_LO = fev_pkg::FRAC_SHIFT + R_W - 1;
   localparam logic signed [R_W-1:0] SAT_MAX = {1'b0, {(R_W-1){1'b1}}};
   localparam logic signed [R_W-1:0] SAT_MIN = {1'b1, {(R_W-1){1'b0}}};

   // storage
   logic [E_W-1:0] cov_mem  [COV_DEPTH];
   logic [E_W-1:0] coef_mem [COEF_DEPTH];
   logic [COV_AW-1:0]  cov_waddr, cov_raddr;
   logic [COEF_AW-1:0] coef_waddr, coef_raddr;

   // pipeline
   fev_pkg::fev_tag_type      tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff;
   logic signed [E_W-1:0]     cov_rd_ff, coef_rd_ff, aj_ff, aj_use, s2_ff;
   logic signed [P_W-1:0]     p_ff, p_in;
   logic signed [HALF:0]      p_lo_s;
   logic signed [HALF-1:0]    p_hi_s;
   logic signed [P_W:0]       pp_lo_ff, pp_lo_in;
   logic signed [P_W-1:0]     pp_hi_ff, pp_hi_in;
   logic signed [SUM_W-1:0]   hi_part, lo_ext, sum_w;
   logic signed [T_W-1:0]     sum_x, term_ff, term_in;
   logic signed [A_W-1:0]     acc_ff, acc_in, acc_base;
   logic [A_W-1:TOP_LO]       acc_top;
   logic signed [R_W-1:0]     sat_val;
   logic                      rsp_valid_ff, rsp_last_ff;
   logic [fev_pkg::IDX_W-1:0] rsp_var_index_ff;
   logic signed [R_W-1:0]     rsp_variance_ff;

   assign cov_waddr  = {VW'(req_row_index), VW'(req_col_index)};
   assign cov_raddr  = {rd_k, rd_j};
   assign coef_waddr = {HW'(req_horizon_index), VW'(req_row_index), VW'(req_col_index)};
   assign coef_raddr = {rd_h, rd_i, rd_k};

   // covariance memory: S(k,j)
   always_ff @(posedge clock) begin
      if (cmd.cov_we) begin
         cov_mem[cov_waddr] <= req_elem_value;
      end
      cov_rd_ff <= cov_mem[cov_raddr];
   end

   // coefficient memory: A[h](i,k)
   always_ff @(posedge clock) begin
      if (cmd.coef_we) begin
         coef_mem[coef_waddr] <= req_elem_value;
      end
      coef_rd_ff <= coef_mem[coef_raddr];
   end

   // stage 2: a_j * a_k; the diagonal beat supplies a_j for its row
   assign aj_use = tag1_ff.diag ? coef_rd_ff : aj_ff;
   assign p_in   = aj_use * coef_rd_ff;

   always_ff @(posedge clock) begin
      if (tag1_ff.valid && tag1_ff.diag) begin
         aj_ff <= coef_rd_ff;
      end
      p_ff  <= p_in;
      s2_ff <= cov_rd_ff;
   end

   // stage 3: 64x32 product as two partial products of its 32-bit halves
   assign p_lo_s   = {1'b0, p_ff[HALF-1:0]};
   assign p_hi_s   = p_ff[P_W-1:HALF];
   assign pp_lo_in = p_lo_s * s2_ff;
   assign pp_hi_in = p_hi_s * s2_ff;

   always_ff @(posedge clock) begin
      pp_lo_ff <= pp_lo_in;
      pp_hi_ff <= pp_hi_in;
   end

   // stage 4: combine partials, double off-diagonal terms
   assign hi_part = {pp_hi_ff, {HALF{1'b0}}};
   assign lo_ext  = SUM_W'(pp_lo_ff);
   assign sum_w   = hi_part + lo_ext;
   assign sum_x   = T_W'(sum_w);
   assign term_in = tag3_ff.diag ? sum_x : (sum_x <<< 1);

   always_ff @(posedge clock) begin
      term_ff <= term_in;
   end

   // stage 5: accumulate, restart on first term of a variable
   assign acc_base = tag4_ff.first ? '0 : acc_ff;
   assign acc_in   = acc_base + A_W'(term_ff);

   always_ff @(posedge clock) begin
      if (tag4_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   // floor to Q32.32 and saturate
   assign acc_top = acc_ff[A_W-1:TOP_LO];
   always_comb begin
      if (acc_top == '0 || acc_top == '1) begin
         sat_val = acc_ff[TOP_LO:fev_pkg::FRAC_SHIFT];
      end else if (acc_ff[A_W-1]) begin
         sat_val = SAT_MIN;
      end else begin
         sat_val = SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (tag5_ff.valid && tag5_ff.done) begin
         rsp_var_index_ff <= tag5_ff.var_idx;
         rsp_variance_ff  <= sat_val;
         rsp_last_ff      <= tag5_ff.final_var;
      end
   end

   // tag pipeline and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff      <= '0;
         tag2_ff      <= '0;
         tag3_ff      <= '0;
         tag4_ff      <= '0;
         tag5_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag1_ff      <= cmd.tag;
         tag2_ff      <= tag1_ff;
         tag3_ff      <= tag2_ff;
         tag4_ff      <= tag3_ff;
         tag5_ff      <= tag4_ff;
         rsp_valid_ff <= tag5_ff.valid && tag5_ff.done;
      end
   end

   assign pipe_busy = tag1_ff.valid || tag2_ff.valid || tag3_ff.valid ||
                      tag4_ff.valid || tag5_ff.valid;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_var_index = rsp_var_index_ff;
   assign rsp_variance  = rsp_variance_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// File: hw/rtl/forecast_error_variance.sv
// ============================================================================
// Load beats give no result. A start beat keeps busy high while one product
// term a cycle goes through the shared multiplier pipeline, then while it
// drains; variable i reports once its last term has passed the pipeline and
// the result register. The result strobe is a single cycle; no backpressure.
// Reset clears control and sets num_vars to 8, horizon_count to 16; the
// covariance and coefficient memories are not cleared and must be loaded.
// ============================================================================
// forecast_error_variance
// Forecast error variance engine: per variable, sum over horizons of the
// quadratic form of its coefficient row with the covariance matrix.
// ============================================================================
module forecast_error_variance #(
   parameter int MAX_VARS    = fev_pkg::MAX_VARS_DEF,
   parameter int MAX_HORIZON = fev_pkg::MAX_HORIZON_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // command channel
   input  logic                               start,
   output logic                               busy,
   input  logic [fev_pkg::CMD_W-1:0]          req_cmd,
   input  logic [fev_pkg::IDX_W-1:0]          req_row_index,
   input  logic [fev_pkg::IDX_W-1:0]          req_col_index,
   input  logic [fev_pkg::HZ_W-1:0]           req_horizon_index,
   input  logic signed [fev_pkg::ELEM_W-1:0]  req_elem_value,
   // result channel
   output logic                               rsp_valid,
   output logic [fev_pkg::IDX_W-1:0]          rsp_var_index,
   output logic signed [fev_pkg::RES_W-1:0]   rsp_variance,
   output logic                               rsp_last,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [fev_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [fev_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [fev_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   localparam int VW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
   localparam int HW = (MAX_HORIZON > 1) ? $clog2(MAX_HORIZON) : 1;

   logic [fev_pkg::NV_W-1:0] num_vars;
   logic [fev_pkg::HC_W-1:0] horizon_count;
   fev_pkg::fev_cmd_type     cmd;
   logic                     pipe_busy;
   logic [HW-1:0]            rd_h;
   logic [VW-1:0]            rd_i, rd_j, rd_k;

   fev_regs u_regs (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .num_vars      (num_vars),
      .horizon_count (horizon_count)
   );

   fev_ctrl #(
      .MAX_VARS    (MAX_VARS),
      .MAX_HORIZON (MAX_HORIZON)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_horizon_index (req_horizon_index),
      .num_vars          (num_vars),
      .horizon_count     (horizon_count),
      .pipe_busy         (pipe_busy),
      .cmd               (cmd),
      .rd_h              (rd_h),
      .rd_i              (rd_i),
      .rd_j              (rd_j),
      .rd_k              (rd_k)
   );

   fev_dp #(
      .MAX_VARS    (MAX_VARS),
      .MAX_HORIZON (MAX_HORIZON)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .rd_h              (rd_h),
      .rd_i              (rd_i),
      .rd_j              (rd_j),
      .rd_k              (rd_k),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_horizon_index (req_horizon_index),
      .req_elem_value    (req_elem_value),
      .pipe_busy         (pipe_busy),
      .rsp_valid         (rsp_valid),
      .rsp_var_index     (rsp_var_index),
      .rsp_variance      (rsp_variance),
      .rsp_last          (rsp_last)
   );

endmodule
